// ----- sv/mcpwm_pkg.sv -----
// Shared types, constants and reset tables of the multi-channel PWM generator.
// No dependencies; imported by the RAM-backed datapath in the top level.
`default_nettype none

package mcpwm_pkg;

    localparam int CHANNELS     = 6;
    localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W        = 32;
    localparam int DUTY_W       = 10;
    localparam int DUTY_FULL    = 1000;
    localparam int DUTY_DEFAULT = 500;
    localparam int IN_W         = 40;
    localparam int OUT_W        = 16;
    localparam int MASK_W       = 6;

    // Split period into quotient and remainder by 1000 with a reciprocal
    // that is exact for any 32-bit period.
    localparam int               QUO_W     = 23;
    localparam int               RCP_W     = 29;
    localparam logic [RCP_W-1:0] RCP_1000  = 29'h10624DD3;
    localparam int               RCP_SHIFT = 38;

    // Divide duty times remainder (below 2^20) by 1000.
    localparam int                LO_W       = 20;
    localparam int                LRCP_W     = 21;
    localparam logic [LRCP_W-1:0] LRCP_1000  = 21'd1073742;
    localparam int                LRCP_SHIFT = 30;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_ENABLE  = 3'd1,
        CMD_DISABLE = 3'd2,
        CMD_RESTART = 3'd3,
        CMD_PERIOD  = 3'd4,
        CMD_DUTY    = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_PREAD,
        ST_DIV,
        ST_FRAC,
        ST_SUM,
        ST_PWRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  period;
        logic [CNT_W-1:0]  threshold;
        logic [DUTY_W-1:0] duty;
    } par_t;

    function automatic logic [CNT_W-1:0] reset_period(input logic [2:0] idx);
        logic [CNT_W-1:0] p;
        case (idx)
            3'd1:    p = 32'd15000;
            3'd3:    p = 32'd20000;
            default: p = 32'd10000;
        endcase
        return p;
    endfunction

    // Default duty is one half, so the threshold is half the period.
    function automatic par_t reset_par(input logic [CH_W-1:0] idx);
        par_t r;
        r.period    = reset_period(3'(idx));
        r.threshold = r.period >> 1;
        r.duty      = DUTY_W'(DUTY_DEFAULT);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mcpwm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mcpwm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/multi_channel_pwm_generator_unit.sv -----
// Top level of the command-driven multi-channel PWM generator.
// Depends on mcpwm_pkg and two mcpwm_ram instances (counts, channel settings).
//
// Usage:
//   Input stream s_*: s_tuser carries the command, s_tdata the channel and
//   value. Output stream m_*: one item per command with the pin levels and
//   enable flags after the command has acted.
//   Counts sit in one RAM, period/threshold/duty in another; enable and pin
//   levels are flops. A tick walks the channels through the count RAM, one
//   channel per cycle, read-modify-write with the read of the next channel
//   overlapping the write of the current one.
//   From accept to result: a tick walks the channels; set period or set duty
//   runs reciprocal multiplications (ST_PREAD to ST_SUM), then the write-back
//   (ST_PWRITE); any other command or a channel out of range goes to ST_OUT.
//   One command is in flight; the next is taken when the result appears.
//   Reset clears enables, pin levels, the output valid flag and the per-entry
//   valid bits; an entry not written since reset reads as its default.
//   When the receiver stalls, the result holds in the output register; the
//   next command is accepted and worked on, then waits in ST_OUT until the register is free.
`default_nettype none

module multi_channel_pwm_generator_unit (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [mcpwm_pkg::IN_W-1:0]  s_tdata,  // channel[2:0], value[34:3]
    input  wire logic [2:0]                s_tuser,  // cmd[2:0]
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [mcpwm_pkg::OUT_W-1:0]    m_tdata   // pin_levels[5:0], enabled_mask[11:6]
);

    import mcpwm_pkg::*;

    localparam int PAR_W = $bits(par_t);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [CH_W-1:0]     idx_reg;
    logic [CNT_W-1:0]    value_reg;
    logic [CNT_W-1:0]    period_reg;
    logic [DUTY_W-1:0]   duty_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [DUTY_W-1:0]   rem_reg;
    logic [CNT_W-1:0]    hi_reg;
    logic [LO_W-1:0]     lo_reg;
    logic [CNT_W-1:0]    thr_reg;
    logic [CHANNELS-1:0] en_reg;
    logic [CHANNELS-1:0] lvl_reg;
    logic [CHANNELS-1:0] cnt_vld_reg;
    logic [CHANNELS-1:0] par_vld_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic                in_acc;
    cmd_t                in_cmd;
    logic [2:0]          in_ch;
    logic [CNT_W-1:0]    in_value;
    logic                in_ch_ok;
    logic                out_free;

    logic [CH_W-1:0]     rd_addr;
    logic                cnt_we;
    logic [CNT_W-1:0]    cnt_wdata;
    logic [CNT_W-1:0]    cnt_q;
    logic                par_we;
    par_t                par_wdata;
    logic [PAR_W-1:0]    par_q;

    logic [CNT_W-1:0]    cnt_cur;
    logic [CNT_W-1:0]    cnt_inc;
    par_t                par_cur;
    logic                tick_fall;
    logic                tick_rise;
    logic [DUTY_W-1:0]   duty_new;
    logic [CNT_W-1:0]    period_new;

    logic [CNT_W+RCP_W-1:0]  quo_prod;
    logic [CNT_W-1:0]        quo_scaled;
    logic [CNT_W-1:0]        rem_full;
    logic [CNT_W-1:0]        hi_prod;
    logic [LO_W+LRCP_W-1:0]  frac_prod;

    assign in_acc   = s_tvalid && s_tready;
    assign in_cmd   = cmd_t'(s_tuser);
    assign in_ch    = s_tdata[2:0];
    assign in_value = s_tdata[34:3];
    assign in_ch_ok = {1'b0, in_ch} < 4'(CHANNELS);
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    mcpwm_ram #(.WIDTH(CNT_W), .DEPTH(CHANNELS)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (idx_reg),
        .wdata (cnt_wdata),
        .raddr (rd_addr),
        .rdata (cnt_q)
    );

    mcpwm_ram #(.WIDTH(PAR_W), .DEPTH(CHANNELS)) u_par_ram (
        .aclk  (aclk),
        .we    (par_we),
        .waddr (idx_reg),
        .wdata (par_wdata),
        .raddr (rd_addr),
        .rdata (par_q)
    );

    // Entries not written since reset read as their defaults.
    assign cnt_cur   = cnt_vld_reg[idx_reg] ? cnt_q : '0;
    assign par_cur   = par_vld_reg[idx_reg] ? par_t'(par_q) : reset_par(idx_reg);
    assign cnt_inc   = cnt_cur + CNT_W'(1);
    assign tick_fall = lvl_reg[idx_reg] && (cnt_inc > par_cur.threshold);
    assign tick_rise = !lvl_reg[idx_reg] && (cnt_inc >= par_cur.period);

    assign duty_new   = (cmd_reg == CMD_DUTY)
                      ? ((value_reg > CNT_W'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL)
                                                         : value_reg[DUTY_W-1:0])
                      : par_cur.duty;
    assign period_new = (cmd_reg == CMD_PERIOD) ? value_reg : par_cur.period;

    // threshold = duty * (period / 1000) + (duty * (period % 1000)) / 1000
    assign quo_prod   = {{RCP_W{1'b0}}, period_new} * {{CNT_W{1'b0}}, RCP_1000};
    assign quo_scaled = {{(CNT_W-QUO_W){1'b0}}, quo_reg} * CNT_W'(DUTY_FULL);
    assign rem_full   = period_reg - quo_scaled;
    assign hi_prod    = {{(CNT_W-QUO_W){1'b0}}, quo_reg}
                      * {{(CNT_W-DUTY_W){1'b0}}, duty_reg};
    assign frac_prod  = {{LRCP_W{1'b0}}, lo_reg} * {{LO_W{1'b0}}, LRCP_1000};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_cmd == CMD_TICK) begin
                        state_next = ST_TICK;
                    end else if (in_ch_ok &&
                                 (in_cmd == CMD_PERIOD || in_cmd == CMD_DUTY)) begin
                        state_next = ST_PREAD;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_TICK: begin
                if (idx_reg == CH_W'(CHANNELS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_PREAD:  state_next = ST_DIV;
            ST_DIV:    state_next = ST_FRAC;
            ST_FRAC:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_PWRITE;
            ST_PWRITE: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        rd_addr   = idx_reg;
        cnt_we    = 1'b0;
        cnt_wdata = cnt_inc;
        par_we    = 1'b0;
        par_wdata = '{period: period_reg, threshold: thr_reg, duty: duty_reg};
        case (state_reg)
            ST_IDLE: begin
                rd_addr = (in_cmd == CMD_TICK) ? '0 : in_ch[CH_W-1:0];
            end
            ST_TICK: begin
                rd_addr   = idx_reg + CH_W'(1);
                cnt_we    = en_reg[idx_reg];
                cnt_wdata = tick_rise ? '0 : cnt_inc;
            end
            ST_PWRITE: begin
                par_we = 1'b1;
            end
            default: begin
                rd_addr = idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            en_reg       <= '0;
            lvl_reg      <= '0;
            cnt_vld_reg  <= '0;
            par_vld_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc && in_ch_ok) begin
                        case (in_cmd)
                            CMD_ENABLE: begin
                                if (!en_reg[in_ch[CH_W-1:0]]) begin
                                    en_reg[in_ch[CH_W-1:0]]      <= 1'b1;
                                    lvl_reg[in_ch[CH_W-1:0]]     <= 1'b1;
                                    cnt_vld_reg[in_ch[CH_W-1:0]] <= 1'b0;
                                end
                            end
                            CMD_DISABLE: begin
                                if (en_reg[in_ch[CH_W-1:0]]) begin
                                    en_reg[in_ch[CH_W-1:0]]      <= 1'b0;
                                    lvl_reg[in_ch[CH_W-1:0]]     <= 1'b0;
                                    cnt_vld_reg[in_ch[CH_W-1:0]] <= 1'b0;
                                end
                            end
                            CMD_RESTART: begin
                                lvl_reg[in_ch[CH_W-1:0]]     <= 1'b1;
                                cnt_vld_reg[in_ch[CH_W-1:0]] <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_TICK: begin
                    if (en_reg[idx_reg]) begin
                        cnt_vld_reg[idx_reg] <= 1'b1;
                        if (tick_fall) begin
                            lvl_reg[idx_reg] <= 1'b0;
                        end
                        if (tick_rise) begin
                            lvl_reg[idx_reg] <= 1'b1;
                        end
                    end
                end
                ST_PWRITE: begin
                    par_vld_reg[idx_reg] <= 1'b1;
                    if (en_reg[idx_reg]) begin
                        lvl_reg[idx_reg]     <= 1'b1;
                        cnt_vld_reg[idx_reg] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    cmd_reg   <= in_cmd;
                    value_reg <= in_value;
                    idx_reg   <= (in_cmd == CMD_TICK) ? '0 : in_ch[CH_W-1:0];
                end
            end
            ST_TICK: begin
                idx_reg <= idx_reg + CH_W'(1);
            end
            ST_PREAD: begin
                duty_reg   <= duty_new;
                period_reg <= period_new;
                quo_reg    <= quo_prod[RCP_SHIFT +: QUO_W];
            end
            ST_DIV: begin
                rem_reg <= rem_full[DUTY_W-1:0];
                hi_reg  <= hi_prod;
            end
            ST_FRAC: begin
                lo_reg <= {{(LO_W-DUTY_W){1'b0}}, duty_reg}
                        * {{(LO_W-DUTY_W){1'b0}}, rem_reg};
            end
            ST_SUM: begin
                thr_reg <= hi_reg
                         + {{(CNT_W-DUTY_W){1'b0}}, frac_prod[LRCP_SHIFT +: DUTY_W]};
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= {{(OUT_W-2*MASK_W){1'b0}},
                                    MASK_W'(en_reg), MASK_W'(lvl_reg)};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
